### rtl/plva_pkg.sv
// ----------------------------------------------------------------------------
// plva_pkg
// Shared types and constants for the per-link variance accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package plva_pkg;

	localparam int DEF_MAX_LINKS = 64;

	localparam int CMD_W    = 3;
	localparam int LINK_W   = 6;
	localparam int SAMPLE_W = 16;
	localparam int SUM_W    = 32;
	localparam int SQ_W     = 48;
	localparam int CNT_W    = 16;
	localparam int OUT_W    = 40;
	localparam int LIU_W    = 7;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 1;
	localparam int DIV_W    = 32;
	localparam int PROD_W   = 64;

	localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_START = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INC   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd3;
	localparam logic [CMD_W-1:0] CMD_QUERY = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_LINKS_IN_USE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_SIZE   = 1'd1;

	localparam logic [LIU_W-1:0] LINKS_IN_USE_RST = 7'd64;

	// Per-link moments as kept in the link memory.
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [SQ_W-1:0]  sq;
	} plva_entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic cap_in;
		logic walk_rst;
		logic clr_step;
		logic q_step;
		logic rmw_wr;
		logic cnt_start;
		logic cnt_inc;
		logic cnt_clr;
		logic acc_clr;
		logic div_start;
		logic out_load_div;
		logic out_load_err;
	} plva_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic sweep_last;
		logic walk_more;
		logic pipe_busy;
		logic n_lt2;
		logic div_done;
		logic out_free;
	} plva_stat_t;

endpackage

`default_nettype wire

### rtl/per_link_variance_accumulator.sv
// ----------------------------------------------------------------------------
// per_link_variance_accumulator
// Running sum and sum of squares per link with a summed sample-variance query.
// ----------------------------------------------------------------------------
// Each link keeps the running sum and sum of squares of its Q8.8 samples in
// one memory word, and a single observation count is shared by all links.
// An add-sample request reads the entry in the cycle the request is accepted
// and writes it back in the next one. Set-count and increment requests finish
// in the cycle they are accepted. A clear request, and reset itself, zero the
// link memory one entry per cycle, and the block takes no request until every
// entry is zeroed. A query walks the links in use one per cycle through a
// read, multiply and accumulate pipeline, then runs a restoring divider that
// produces one quotient bit per cycle; when fewer than two observations have
// been counted, it returns the error status instead. The result waits in an
// output register, so a new request is taken while a previous result is
// still stalled. Configuration writes are taken at any time but must only be
// issued while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module per_link_variance_accumulator #(
	parameter int MAX_LINKS = plva_pkg::DEF_MAX_LINKS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [plva_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [plva_pkg::CFG_W-1:0]      cfg_wdata,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [plva_pkg::CMD_W-1:0]      command,
	input  wire logic [plva_pkg::LINK_W-1:0]     link,
	input  wire logic [plva_pkg::SAMPLE_W-1:0]   sample_value,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [plva_pkg::OUT_W-1:0]           variance_sum,
	output logic                                 status
);
	import plva_pkg::*;

	plva_cmd_t  cmd;
	plva_stat_t stat;

	// The controller sequences every request; the datapath does the work.
	plva_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.stat     (stat),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	plva_dp #(
		.MAX_LINKS(MAX_LINKS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.link           (link),
		.sample_value   (sample_value),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.variance_sum   (variance_sum),
		.status         (status)
	);

endmodule

`default_nettype wire

### rtl/plva_div.sv
// ----------------------------------------------------------------------------
// plva_div
// Restoring radix-2 divider, one quotient bit per cycle, 40-bit saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module plva_div #(
	parameter int DW = 72
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [DW-1:0]               dividend,
	input  wire logic [plva_pkg::DIV_W-1:0]  divisor,
	output logic                             done,
	output logic [plva_pkg::OUT_W-1:0]       quotient
);
	import plva_pkg::*;

	localparam int SW = $clog2(DW + 1);

	logic             busy_q;
	logic             done_q;
	logic [SW-1:0]    step_q;
	logic [DW-1:0]    num_q;
	logic [DW-1:0]    quo_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] den_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W+1:0] diff;
	logic             ge;

	assign trial = {rem_q, num_q[DW-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};
	assign ge    = ~diff[DIV_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == SW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			quo_q <= '0;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[DW-2:0], 1'b0};
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = (|quo_q[DW-1:OUT_W]) ? {OUT_W{1'b1}} : quo_q[OUT_W-1:0];

endmodule

`default_nettype wire

### rtl/plva_ctrl.sv
// ----------------------------------------------------------------------------
// plva_ctrl
// Sequencer for memory clearing, sample and count updates, the query walk and division.
// ----------------------------------------------------------------------------
`default_nettype none

module plva_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire logic [plva_pkg::CMD_W-1:0]  command,
	input  wire plva_pkg::plva_stat_t        stat,
	output logic                             in_stall,
	output plva_pkg::plva_cmd_t              cmd
);
	import plva_pkg::*;

	localparam logic [3:0] S_SWEEP = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_ADD   = 4'd2;
	localparam logic [3:0] S_WALK  = 4'd3;
	localparam logic [3:0] S_DRAIN = 4'd4;
	localparam logic [3:0] S_DIV   = 4'd5;
	localparam logic [3:0] S_OUT   = 4'd6;
	localparam logic [3:0] S_ERR   = 4'd7;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_SWEEP: begin
				cmd.clr_step = 1'b1;
				if (stat.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap_in = 1'b1;
					unique case (command)
						CMD_ADD: begin
							state_d = S_ADD;
						end
						CMD_START: begin
							cmd.cnt_start = 1'b1;
						end
						CMD_INC: begin
							cmd.cnt_inc = 1'b1;
						end
						CMD_CLEAR: begin
							cmd.cnt_clr  = 1'b1;
							cmd.walk_rst = 1'b1;
							state_d      = S_SWEEP;
						end
						CMD_QUERY: begin
							if (stat.n_lt2) begin
								state_d = S_ERR;
							end else begin
								cmd.walk_rst = 1'b1;
								cmd.acc_clr  = 1'b1;
								state_d      = S_WALK;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_ADD: begin
				cmd.rmw_wr = 1'b1;
				state_d    = S_IDLE;
			end
			S_WALK: begin
				if (stat.walk_more) begin
					cmd.q_step = 1'b1;
				end else begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!stat.pipe_busy) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.out_load_div = 1'b1;
					state_d          = S_IDLE;
				end
			end
			S_ERR: begin
				if (stat.out_free) begin
					cmd.out_load_err = 1'b1;
					state_d          = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/plva_dp.sv
// ----------------------------------------------------------------------------
// plva_dp
// Link memory, observation count, moment pipeline, accumulator and output.
// ----------------------------------------------------------------------------
`default_nettype none

module plva_dp #(
	parameter int MAX_LINKS = plva_pkg::DEF_MAX_LINKS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire plva_pkg::plva_cmd_t             cmd,
	output plva_pkg::plva_stat_t                 stat,
	input  wire logic                            cfg_we,
	input  wire logic [plva_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [plva_pkg::CFG_W-1:0]      cfg_wdata,
	input  wire logic [plva_pkg::LINK_W-1:0]     link,
	input  wire logic [plva_pkg::SAMPLE_W-1:0]   sample_value,
	input  wire logic                            out_stall,
	output logic                                 out_valid,
	output logic [plva_pkg::OUT_W-1:0]           variance_sum,
	output logic                                 status
);
	import plva_pkg::*;

	localparam int AW    = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
	localparam int CW    = $clog2(MAX_LINKS + 1);
	localparam int ACC_W = PROD_W + 2 + $clog2(MAX_LINKS);
	localparam int DW    = ACC_W - 1;

	plva_entry_t mem_q [MAX_LINKS];

	logic [LIU_W-1:0]    links_q;
	logic [CNT_W-1:0]    start_q;
	logic [CNT_W-1:0]    count_q;
	logic [CW-1:0]       idx_q;
	logic [CW-1:0]       lim;
	logic [LINK_W-1:0]   link_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic                link_ok_q;
	logic [AW+LINK_W-1:0] link_in_wide;
	logic [AW+LINK_W-1:0] link_q_wide;
	logic [AW-1:0]       raddr;
	logic [AW-1:0]       waddr;
	logic                we;
	plva_entry_t         wdata;
	plva_entry_t         upd;
	plva_entry_t         rd_s1;
	logic                v_s1;
	logic                v_s2;
	logic [PROD_W-1:0]   pp_s2;
	logic [PROD_W-1:0]   pm_s2;
	logic [PROD_W-1:0]   pp;
	logic [PROD_W-1:0]   pm;
	logic [2*SAMPLE_W-1:0] sq_sample;
	logic [ACC_W-1:0]    acc_q;
	logic [CNT_W-1:0]    n_m1;
	logic [DIV_W-1:0]    divisor;
	logic [DW-1:0]       dividend;
	logic                div_done;
	logic [OUT_W-1:0]    quotient;
	logic                out_valid_q;
	logic [OUT_W-1:0]    total_q;
	logic                status_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			links_q <= LINKS_IN_USE_RST;
			start_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_LINKS_IN_USE) begin
				links_q <= cfg_wdata[LIU_W-1:0];
			end
			if (cfg_index == REG_START_SIZE) begin
				start_q <= cfg_wdata[CNT_W-1:0];
			end
		end
	end

	// Observation count, saturating on increment.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_clr) begin
			count_q <= '0;
		end else if (cmd.cnt_start) begin
			count_q <= start_q;
		end else if (cmd.cnt_inc && count_q != {CNT_W{1'b1}}) begin
			count_q <= count_q + 1'b1;
		end
	end

	// Walk index shared by the clearing sweep and the query walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.walk_rst) begin
			idx_q <= '0;
		end else if (cmd.clr_step || cmd.q_step) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_comb begin
		if (32'(links_q) > MAX_LINKS) begin
			lim = CW'(MAX_LINKS);
		end else begin
			lim = CW'(links_q);
		end
	end

	// Captured add-sample request.
	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			link_q    <= link;
			sample_q  <= sample_value;
			link_ok_q <= (32'(link) < MAX_LINKS);
		end
	end

	assign link_in_wide = {{AW{1'b0}}, link};
	assign link_q_wide  = {{AW{1'b0}}, link_q};

	// The idle read at the incoming link feeds the update in the next cycle.
	assign raddr = cmd.q_step ? idx_q[AW-1:0] : link_in_wide[AW-1:0];

	assign sq_sample = sample_q * sample_q;
	assign upd.sum   = rd_s1.sum + SUM_W'(sample_q);
	assign upd.sq    = rd_s1.sq + SQ_W'(sq_sample);

	assign we    = cmd.clr_step || (cmd.rmw_wr && link_ok_q);
	assign waddr = cmd.clr_step ? idx_q[AW-1:0] : link_q_wide[AW-1:0];
	assign wdata = cmd.clr_step ? '0 : upd;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_s1 <= mem_q[raddr];
	end

	// Moment pipeline: read, multiply, accumulate.
	assign pp = count_q * rd_s1.sq;
	assign pm = rd_s1.sum * rd_s1.sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.q_step;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		pp_s2 <= pp;
		pm_s2 <= pm;
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(pp_s2) - ACC_W'(pm_s2);
		end
	end

	assign n_m1     = count_q - 1'b1;
	assign divisor  = {{(DIV_W-CNT_W){1'b0}}, count_q} * {{(DIV_W-CNT_W){1'b0}}, n_m1};
	assign dividend = acc_q[ACC_W-1] ? '0 : acc_q[DW-1:0];

	plva_div #(
		.DW(DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load_div || cmd.out_load_err) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load_div) begin
			total_q  <= quotient;
			status_q <= 1'b0;
		end else if (cmd.out_load_err) begin
			total_q  <= '0;
			status_q <= 1'b1;
		end
	end

	assign out_valid    = out_valid_q;
	assign variance_sum = total_q;
	assign status       = status_q;

	assign stat.sweep_last = (idx_q == CW'(MAX_LINKS - 1));
	assign stat.walk_more  = (idx_q < lim);
	assign stat.pipe_busy  = v_s1 || v_s2;
	assign stat.n_lt2      = (count_q < CNT_W'(2));
	assign stat.div_done   = div_done;
	assign stat.out_free   = !out_valid_q || !out_stall;

endmodule

`default_nettype wire

### rtl/plva_checker.sv
// ----------------------------------------------------------------------------
// plva_checker
// Port-level checks for the per-link variance accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module plva_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	input  wire logic                            in_stall,
	input  wire logic [plva_pkg::CMD_W-1:0]      command,
	input  wire logic                            out_valid,
	input  wire logic                            out_stall,
	input  wire logic [plva_pkg::OUT_W-1:0]      variance_sum,
	input  wire logic                            status
);
	import plva_pkg::*;

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(variance_sum) && $stable(status))
		else $error("stalled result changed");

	// An error result always carries a zero total.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> variance_sum == '0)
		else $error("error result with nonzero total");

	// Add, clear and query requests leave the block stalled after they are accepted.
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall &&
		(command == CMD_ADD || command == CMD_CLEAR || command == CMD_QUERY)
		|=> in_stall)
		else $error("block idle right after a multi-cycle request");

	// Count updates finish in the cycle they are accepted.
	a_count_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (command == CMD_START || command == CMD_INC)
		|=> !in_stall)
		else $error("block busy after a count update");

endmodule

bind per_link_variance_accumulator plva_checker u_plva_checker (.*);

`default_nettype wire

### tb/per_link_variance_accumulator_tb.sv
// ----------------------------------------------------------------------------
// per_link_variance_accumulator_tb
// Self-checking testbench for the per-link variance accumulator.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the per-link sums, sums of squares,
// observation count and registers. It predicts the result of every accepted
// query request with exact 128-bit arithmetic. Each returned result is compared
// field by field against the oldest prediction. A short directed sequence is
// run first, then random requests under several register settings. Random gaps
// are placed on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module per_link_variance_accumulator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import plva_pkg::*;

	localparam int NUM_LINKS   = DEF_MAX_LINKS;
	// A query walks the links in use and then divides. A clear sweeps the memory.
	// This many quiet cycles cover either one with margin.
	localparam int SETTLE      = 250;
	localparam int IDLE_LIMIT  = 5000;
	localparam int PHASE_ITEMS = 200;
	localparam logic [OUT_W-1:0] VAR_MAX = '1;

	typedef struct packed {
		logic [OUT_W-1:0] variance_sum;
		logic             status;
	} variance_result_t;

	// Models the block's state and holds the results that are still owed.
	class variance_scoreboard;
		logic [SUM_W-1:0]   sums[NUM_LINKS];
		logic [SQ_W-1:0]    squares[NUM_LINKS];
		logic [CNT_W-1:0]   count;
		logic [LIU_W-1:0]   links_in_use;
		logic [CNT_W-1:0]   start_size;
		variance_result_t   owed[$];
		int                 errors;

		function void clear_moments();
			foreach (sums[i]) begin
				sums[i] = '0;
				squares[i] = '0;
			end
			count = '0;
		endfunction

		function void reset_state();
			clear_moments();
			links_in_use = LINKS_IN_USE_RST;
			start_size = '0;
			owed.delete();
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			if (idx == REG_LINKS_IN_USE)
				links_in_use = data[LIU_W-1:0];
			else if (idx == REG_START_SIZE)
				start_size = data;
		endfunction

		function void note_request(logic [CMD_W-1:0] cmd, logic [LINK_W-1:0] ln,
				logic [SAMPLE_W-1:0] sample);
			logic [SQ_W-1:0]  sample_sq;
			logic [127:0]     acc;
			logic [127:0]     n_wide;
			logic [127:0]     term_sq;
			logic [127:0]     term_sum;
			logic [127:0]     quotient;
			int               walk;
			variance_result_t res;
			case (cmd)
				CMD_ADD: begin
					sample_sq = SQ_W'(sample);
					sample_sq = sample_sq * sample_sq;
					sums[ln] = sums[ln] + SUM_W'(sample);
					squares[ln] = squares[ln] + sample_sq;
				end
				CMD_START: count = start_size;
				CMD_INC: if (count != '1) count = count + 1'b1;
				CMD_CLEAR: clear_moments();
				CMD_QUERY: begin
					if (count < 2) begin
						res.variance_sum = '0;
						res.status = 1'b1;
					end else begin
						n_wide = 128'(count);
						acc = '0;
						walk = (links_in_use > NUM_LINKS) ? NUM_LINKS : int'(links_in_use);
						for (int i = 0; i < walk; i++) begin
							term_sq = 128'(squares[i]);
							term_sum = 128'(sums[i]);
							acc = acc + n_wide * term_sq - term_sum * term_sum;
						end
						// A negative numerator means the moments do not fit the count.
						if (acc[127]) begin
							res.variance_sum = '0;
						end else begin
							quotient = acc / (n_wide * (n_wide - 1));
							res.variance_sum = (quotient > VAR_MAX) ? VAR_MAX
								: quotient[OUT_W-1:0];
						end
						res.status = 1'b0;
					end
					owed.push_back(res);
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic [OUT_W-1:0] tv, logic st);
			variance_result_t want;
			if (owed.size() == 0) begin
				$display("%0t: unexpected result variance_sum=%0d status=%0d",
					$time, tv, st);
				errors++;
				return;
			end
			want = owed.pop_front();
			if (tv !== want.variance_sum) begin
				$display("%0t: variance_sum expected %0d actual %0d",
					$time, want.variance_sum, tv);
				errors++;
			end
			if (st !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, st);
				errors++;
			end
		endfunction

		function int pending();
			return owed.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [CMD_W-1:0]      command = CMD_ADD;
	logic [LINK_W-1:0]     link = '0;
	logic [SAMPLE_W-1:0]   sample_value = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [OUT_W-1:0]      variance_sum;
	logic                  status;

	variance_scoreboard    sb = new();
	// When set, the matching side runs without gaps or stalls for a while.
	bit                    steady_send = 0;
	bit                    steady_recv = 0;
	int                    stall_left = 0;
	int                    idle_cycles = 0;

	per_link_variance_accumulator i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .link(link), .sample_value(sample_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.variance_sum(variance_sum), .status(status)
	);

	always #5 clk = ~clk;

	// Most gaps are short, and a few are long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(3, 1);
		return $urandom_range(30, 8);
	endfunction

	// The result side stalls at random. Each result is checked at the edge
	// that accepts it. All values are sampled before this edge updates them.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(variance_sum, status);
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (steady_recv) begin
			out_stall <= 1'b0;
		end else begin
			stall_left <= pick_gap();
			out_stall <= 1'b0;
		end
	end

	// The watchdog ends a run in which nothing moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: timeout, nothing accepted for %0d cycles", $time, idle_cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// This task drives one request and holds it until it is accepted. Valid stays
	// high into the next request when no gap follows.
	task automatic send_request(logic [CMD_W-1:0] cmd, logic [LINK_W-1:0] ln,
			logic [SAMPLE_W-1:0] sample);
		int gap;
		in_valid <= 1'b1;
		command <= cmd;
		link <= ln;
		sample_value <= sample;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(cmd, ln, sample);
		gap = steady_send ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// This task lowers valid and waits until every owed result has arrived. It
	// then gives the block time to finish work that produces no result.
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Register writes are issued only while the block is idle.
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		drain_and_settle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	// Samples favor the extremes so that the sums and squares grow quickly.
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int r;
		r = $urandom_range(7);
		if (r == 0) return '1;
		if (r == 1) return '0;
		return SAMPLE_W'($urandom_range(16'hFFFF));
	endfunction

	// Random links mostly fall inside the summed range so that queries see
	// the data. The rest reach every link.
	function automatic logic [LINK_W-1:0] pick_link();
		int span;
		span = (sb.links_in_use == 0) ? 1
			: (sb.links_in_use > NUM_LINKS) ? NUM_LINKS : int'(sb.links_in_use);
		if ($urandom_range(1)) return LINK_W'($urandom_range(span - 1));
		return LINK_W'($urandom_range(NUM_LINKS - 1));
	endfunction

	task automatic random_phase(int items);
		int r;
		logic [CMD_W-1:0] unknown_cmd;
		for (int k = 0; k < items; k++) begin
			if (k % 50 == 0) begin
				steady_send = ($urandom_range(3) == 0);
				steady_recv = ($urandom_range(3) == 0);
			end
			// Once during the phase, the sender holds off until all results are back.
			if (k == items / 2) drain_and_settle();
			r = $urandom_range(99);
			if (r < 55) begin
				send_request(CMD_ADD, pick_link(), pick_sample());
			end else if (r < 70) begin
				send_request(CMD_INC, LINK_W'($urandom_range(63)),
					SAMPLE_W'($urandom_range(16'hFFFF)));
			end else if (r < 74) begin
				send_request(CMD_START, LINK_W'($urandom_range(63)),
					SAMPLE_W'($urandom_range(16'hFFFF)));
			end else if (r < 76) begin
				send_request(CMD_CLEAR, LINK_W'($urandom_range(63)),
					SAMPLE_W'($urandom_range(16'hFFFF)));
			end else if (r < 97) begin
				send_request(CMD_QUERY, LINK_W'($urandom_range(63)),
					SAMPLE_W'($urandom_range(16'hFFFF)));
			end else begin
				unknown_cmd = CMD_W'($urandom_range(7, 5));
				send_request(unknown_cmd, LINK_W'($urandom_range(63)),
					SAMPLE_W'($urandom_range(16'hFFFF)));
			end
		end
	endtask

	initial begin
		sb.reset_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// The directed part runs under the reset register values.
		send_request(CMD_QUERY, 6'd0, 16'd0);      // no observations counted yet
		send_request(CMD_START, 6'd0, 16'd0);      // start size of zero
		send_request(CMD_INC, 6'd63, 16'hFFFF);
		send_request(CMD_QUERY, 6'd63, 16'hFFFF);  // a single observation
		send_request(CMD_ADD, 6'd0, 16'hFFFF);
		send_request(CMD_ADD, 6'd63, 16'hFFFF);
		send_request(CMD_ADD, 6'd63, 16'h0000);
		send_request(CMD_ADD, 6'd0, 16'h0001);
		send_request(CMD_INC, 6'd0, 16'd0);
		send_request(CMD_QUERY, 6'd0, 16'd0);
		send_request(3'd5, 6'd1, 16'h1234);        // unknown codes do nothing
		send_request(3'd6, 6'd2, 16'h5678);
		send_request(3'd7, 6'd3, 16'h9ABC);
		send_request(CMD_QUERY, 6'd0, 16'd0);
		// Three equal samples against a count of two make the numerator negative.
		send_request(CMD_CLEAR, 6'd0, 16'd0);
		send_request(CMD_ADD, 6'd10, 16'h8000);
		send_request(CMD_ADD, 6'd10, 16'h8000);
		send_request(CMD_ADD, 6'd10, 16'h8000);
		send_request(CMD_INC, 6'd0, 16'd0);
		send_request(CMD_INC, 6'd0, 16'd0);
		send_request(CMD_QUERY, 6'd0, 16'd0);
		send_request(CMD_CLEAR, 6'd0, 16'd0);
		send_request(CMD_QUERY, 6'd0, 16'd0);

		// Each phase writes both registers. Extremes include a links-in-use value
		// of zero, values above the link count, and a start size that saturates.
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin write_register(REG_LINKS_IN_USE, 16'd64);  write_register(REG_START_SIZE, 16'd0);     end
				1: begin write_register(REG_LINKS_IN_USE, 16'd1);   write_register(REG_START_SIZE, 16'hFFFF);  end
				2: begin write_register(REG_LINKS_IN_USE, 16'd0);   write_register(REG_START_SIZE, 16'd2);     end
				3: begin write_register(REG_LINKS_IN_USE, 16'd127); write_register(REG_START_SIZE, 16'd3);     end
				4: begin write_register(REG_LINKS_IN_USE, 16'd100); write_register(REG_START_SIZE, 16'd1);     end
				5: begin write_register(REG_LINKS_IN_USE, 16'd33);  write_register(REG_START_SIZE, 16'd500);   end
				6: begin write_register(REG_LINKS_IN_USE, 16'd2);   write_register(REG_START_SIZE, 16'hFFFE);  end
				default: begin
					write_register(REG_LINKS_IN_USE, CFG_W'($urandom_range(64, 1)));
					write_register(REG_START_SIZE, CFG_W'($urandom_range(16'hFFFF)));
				end
			endcase
			random_phase(PHASE_ITEMS);
		end

		steady_recv = 0;
		drain_and_settle();
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
